>>> rtl/core/tpdr_pkg.sv
`default_nettype none

package tpdr_pkg;

  // Width and reset value of the match tolerance register.
  localparam int unsigned TOL_W = 31;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(3);

  // Result status codes.
  typedef enum logic [1:0] {
    OUTCOME_NEW  = 2'd0,
    OUTCOME_DUP  = 2'd1,
    OUTCOME_FULL = 2'd2
  } outcome_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;   // take an input transaction this cycle
    logic issue;      // read the entry under the scan index and advance it
    logic take_hit;   // latch a duplicate result from the hit stage
    logic take_new;   // append the point and latch a new-point result
    logic take_full;  // latch a store-full result
    logic emit;       // move the latched result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;   // an input transaction is offered
    logic hit;        // the hit stage holds a match
    logic scan_end;   // every stored entry has been read
    logic pipe_busy;  // a read is still on its way to the compare stage
    logic full;       // the store holds TABLE_DEPTH points
    logic out_free;   // the output register can be loaded this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/tpdr_if.sv
`default_nettype none

interface tpdr_in_if #(
  parameter int unsigned COORD_W = 32
);
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic        [15:0]        point_number;

  modport source (output valid, point_x, point_y, point_number, input ready);
  modport sink   (input valid, point_x, point_y, point_number, output ready);
endinterface

interface tpdr_out_if #(
  parameter int unsigned ID_W = 9
);
  logic            valid;
  logic            ready;
  logic [15:0]     echo_number;
  logic [ID_W-1:0] assigned_id;
  logic [1:0]      outcome;

  modport source (output valid, echo_number, assigned_id, outcome, input ready);
  modport sink   (input valid, echo_number, assigned_id, outcome, output ready);
endinterface

interface tpdr_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tpdr_pkg::TOL_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tpdr_ctrl.sv
`default_nettype none

module tpdr_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  tpdr_pkg::dp_stat_t  stat_i,
  output tpdr_pkg::ctrl_cmd_t cmd_o
);
  import tpdr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // The first hit out of the in-order compare stage wins.
        if (stat_i.hit) begin
          cmd_o.take_hit = 1'b1;
          state_d        = ST_DONE;
        end else if (!stat_i.scan_end) begin
          cmd_o.issue = 1'b1;
        end else if (!stat_i.pipe_busy) begin
          if (stat_i.full) begin
            cmd_o.take_full = 1'b1;
          end else begin
            cmd_o.take_new = 1'b1;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.take_hit, cmd_o.take_new, cmd_o.take_full}) <= 1)
    else $error("more than one result latched in a cycle");
  a_no_issue_after_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take_hit |=> !cmd_o.issue && !cmd_o.take_new && !cmd_o.take_full)
    else $error("scan continued after a duplicate was found");
  a_append_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take_new |-> stat_i.scan_end && !stat_i.pipe_busy && !stat_i.hit)
    else $error("point appended before the scan drained");
`endif

endmodule

`default_nettype wire

>>> rtl/core/tpdr_dp.sv
`default_nettype none

module tpdr_dp #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  tpdr_in_if.sink             in_i,
  tpdr_out_if.source          out_o,
  tpdr_cfg_if.sink            cfg_i,
  input  tpdr_pkg::ctrl_cmd_t cmd_i,
  output tpdr_pkg::dp_stat_t  stat_o
);
  import tpdr_pkg::*;

  localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W = (COORD_WIDTH > TOL_W) ? COORD_WIDTH : TOL_W;
  localparam logic [COORD_WIDTH-1:0] SIGN_BIT = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  logic [TOL_W-1:0]       tol_q;
  logic [COORD_WIDTH-1:0] kx_q, ky_q;
  logic [15:0]            num_q;
  logic [CNT_W-1:0]       count_q, scan_idx_q, s1_idx_q, hit_idx_q;
  logic                   s1_vld_q, hit_q;
  logic [COORD_WIDTH-1:0] rd_x_q, rd_y_q;
  logic [CNT_W-1:0]       res_id_q, res_id_d;
  outcome_e               res_kind_q, res_kind_d;
  logic                   out_valid_q;
  logic [15:0]            out_num_q;
  logic [CNT_W-1:0]       out_id_q;
  outcome_e               out_kind_q;
  logic                   in_fire, match_x, match_y;

  logic [2*COORD_WIDTH-1:0] mem_q [TABLE_DEPTH];

  // |a - b| of two order keys, exact at the coordinate width.
  function automatic logic [COORD_WIDTH-1:0] abs_diff(
    input logic [COORD_WIDTH-1:0] a,
    input logic [COORD_WIDTH-1:0] b
  );
    logic [COORD_WIDTH:0] ab;
    logic [COORD_WIDTH:0] ba;
    ab = {1'b0, a} - {1'b0, b};
    ba = {1'b0, b} - {1'b0, a};
    return ab[COORD_WIDTH] ? ba[COORD_WIDTH-1:0] : ab[COORD_WIDTH-1:0];
  endfunction

  assign in_fire     = in_i.valid && cmd_i.in_ready;
  assign in_i.ready  = cmd_i.in_ready;
  assign cfg_i.ready = 1'b1;

  assign match_x = CMP_W'(abs_diff(kx_q, rd_x_q)) < CMP_W'(tol_q);
  assign match_y = CMP_W'(abs_diff(ky_q, rd_y_q)) < CMP_W'(tol_q);

  assign stat_o.in_valid  = in_i.valid;
  assign stat_o.hit       = hit_q;
  assign stat_o.scan_end  = (scan_idx_q == count_q);
  assign stat_o.pipe_busy = s1_vld_q;
  assign stat_o.full      = (count_q == DEPTH_CNT);
  assign stat_o.out_free  = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_i.valid) begin
      tol_q <= cfg_i.data;
    end
  end

  // Control state: fill count, scan pointer, pipeline valids, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scan_idx_q  <= '0;
      s1_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        scan_idx_q <= '0;
      end else if (cmd_i.issue) begin
        scan_idx_q <= scan_idx_q + CNT_W'(1);
      end
      if (cmd_i.take_new) begin
        count_q <= count_q + CNT_W'(1);
      end
      s1_vld_q <= !in_fire && cmd_i.issue;
      hit_q    <= !in_fire && s1_vld_q && match_x && match_y;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kx_q  <= COORD_WIDTH'(in_i.point_x) ^ SIGN_BIT;
      ky_q  <= COORD_WIDTH'(in_i.point_y) ^ SIGN_BIT;
      num_q <= in_i.point_number;
    end
    if (cmd_i.issue) begin
      s1_idx_q <= scan_idx_q;
    end
    hit_idx_q <= s1_idx_q;
    if (cmd_i.take_hit || cmd_i.take_new || cmd_i.take_full) begin
      res_id_q   <= res_id_d;
      res_kind_q <= res_kind_d;
    end
    if (cmd_i.emit) begin
      out_num_q  <= num_q;
      out_id_q   <= res_id_q;
      out_kind_q <= res_kind_q;
    end
  end

  always_comb begin
    res_id_d   = '0;
    res_kind_d = OUTCOME_FULL;
    if (cmd_i.take_hit) begin
      res_id_d   = hit_idx_q + CNT_W'(1);
      res_kind_d = OUTCOME_DUP;
    end else if (cmd_i.take_new) begin
      res_id_d   = count_q + CNT_W'(1);
      res_kind_d = OUTCOME_NEW;
    end
  end

  // Point store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_new) begin
      mem_q[count_q[AW-1:0]] <= {ky_q, kx_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      {rd_y_q, rd_x_q} <= mem_q[scan_idx_q[AW-1:0]];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.echo_number = out_num_q;
  assign out_o.assigned_id = out_id_q;
  assign out_o.outcome     = out_kind_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_CNT)
    else $error("fill count beyond store depth");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_idx_q <= count_q)
    else $error("scan pointer passed the fill count");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !out_valid_q || out_o.ready)
    else $error("output register overwritten while a result waits");
  a_no_append_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_new |-> count_q != DEPTH_CNT)
    else $error("append into a full store");
`endif

endmodule

`default_nettype wire

>>> rtl/core/tolerant_point_dedup_renumber.sv
`default_nettype none
// Channel  Role    Payload                                 Handshake
// in_i     sink    point_x, point_y, point_number          valid/ready
// out_o    source  echo_number, assigned_id, outcome       valid/ready
// cfg_i    sink    data (match_tolerance, 31 bits)         valid/ready, ready always high
//
// A new or store-full point reaches the output register only after every stored point has been
// read and compared; a duplicate of the point with id k gets there once the entry with id k has
// been compared, and the next point is taken only after that. The single read port of the point
// store, read once per cycle, sets the length of each scan. Reset clears the fill count, so the
// store starts empty with no clearing pass; the tolerance resets to 3. A stalled output holds
// its result while the next point is accepted; that point waits after its scan.
module tolerant_point_dedup_renumber #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  tpdr_in_if.sink    in_i,
  tpdr_out_if.source out_o,
  tpdr_cfg_if.sink   cfg_i
);
  import tpdr_pkg::*;

  // Commands flow controller -> datapath, status the other way.
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequence each point: accept, scan the store in order, then report.
  tpdr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Hold the store, the tolerance, the compare pipeline and the output register.
  tpdr_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
  import tpdr_pkg::*;

  localparam int unsigned DEPTH   = 256;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned ID_W    = 9;

  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0]        SIGN_BIT  = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [TOL_W-1:0]          TOL_MAX   = {TOL_W{1'b1}};

  // Quiet window, counted in transactions: no idling on either side inside it.
  localparam int QUIET_LO = 250;
  localparam int QUIET_HI = 420;

  // Drain time after the last result: a full scan plus pipeline slack.
  localparam int DRAIN_CYCLES = DEPTH + 40;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [15:0]               number;
  } point_t;

  typedef struct packed {
    logic [15:0]     number;
    logic [ID_W-1:0] id;
    outcome_e        outcome;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  tpdr_in_if  #(.COORD_W(COORD_W)) in_bus ();
  tpdr_out_if #(.ID_W(ID_W))       out_bus ();
  tpdr_cfg_if                      cfg_bus ();

  tolerant_point_dedup_renumber #(
    .TABLE_DEPTH(DEPTH),
    .COORD_WIDTH(COORD_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus),
    .cfg_i (cfg_bus)
  );

  // Pending traffic, filled by the stimulus process and drained by the drivers.
  point_t           pending_points[$];
  logic [TOL_W-1:0] pending_tolerances[$];

  // Expected verdicts, oldest first.
  verdict_t expected_verdicts[$];

  // Shadow of the block: tolerance register and the key store in arrival order.
  logic [TOL_W-1:0]   shadow_tolerance;
  logic [COORD_W-1:0] shadow_key_x[DEPTH];
  logic [COORD_W-1:0] shadow_key_y[DEPTH];
  int                 shadow_fill;

  // Points already queued, used to aim new points close to old ones.
  logic signed [COORD_W-1:0] sent_x[$];
  logic signed [COORD_W-1:0] sent_y[$];
  logic [TOL_W-1:0]          stim_tolerance;

  int points_queued;
  int points_accepted;
  int results_seen;
  int tolerance_writes;
  int mismatch_count;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Reset once, with every block input at a known value from time zero.
  initial begin
    rst_ni               = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.point_x       = '0;
    in_bus.point_y       = '0;
    in_bus.point_number  = '0;
    out_bus.ready        = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.data         = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Classify one point against the shadow store and update it, in arrival order.
  // The first stored point strictly inside the tolerance on both axes wins.
  task automatic classify_point(input point_t p, output verdict_t v);
    logic [COORD_W-1:0] kx;
    logic [COORD_W-1:0] ky;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [COORD_W-1:0] bound;
    bit                 found;
    int                 k;
    // Flip the sign bit so unsigned order follows signed order; the
    // differences then never wrap.
    kx        = p.x ^ SIGN_BIT;
    ky        = p.y ^ SIGN_BIT;
    bound     = COORD_W'(shadow_tolerance);
    found     = 1'b0;
    v.number  = p.number;
    v.id      = '0;
    v.outcome = OUTCOME_FULL;
    for (k = 0; k < shadow_fill && !found; k++) begin
      dx = (kx >= shadow_key_x[k]) ? kx - shadow_key_x[k] : shadow_key_x[k] - kx;
      dy = (ky >= shadow_key_y[k]) ? ky - shadow_key_y[k] : shadow_key_y[k] - ky;
      if (dx < bound && dy < bound) begin
        found     = 1'b1;
        v.id      = ID_W'(k + 1);
        v.outcome = OUTCOME_DUP;
      end
    end
    // No match: append while there is room, else report a full store.
    if (!found && shadow_fill < DEPTH) begin
      shadow_key_x[shadow_fill] = kx;
      shadow_key_y[shadow_fill] = ky;
      shadow_fill++;
      v.id      = ID_W'(shadow_fill);
      v.outcome = OUTCOME_NEW;
    end
  endtask

  // Point driver: hold a transaction until it is taken, then advance or idle.
  always @(posedge clk_i) begin : point_driver
    point_t p;
    bit     quiet;
    quiet = points_accepted >= QUIET_LO && points_accepted < QUIET_HI;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (pending_points.size() != 0 && (quiet || $urandom_range(99) >= 16)) begin
        p = pending_points.pop_front();
        in_bus.valid        <= 1'b1;
        in_bus.point_x      <= p.x;
        in_bus.point_y      <= p.y;
        in_bus.point_number <= p.number;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Result sink: drop ready at random, except inside the quiet window.
  always @(posedge clk_i) begin : result_sink
    bit quiet;
    quiet = results_seen >= QUIET_LO && results_seen < QUIET_HI;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= quiet || $urandom_range(99) >= 16;
    end
  end

  // Tolerance writer: one transaction per request; mirror it into the shadow on acceptance.
  always @(posedge clk_i) begin : tolerance_writer
    if (!rst_ni) begin
      cfg_bus.valid    <= 1'b0;
      shadow_tolerance  = TOL_RESET;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        shadow_tolerance = cfg_bus.data;
        tolerance_writes++;
      end
      if (!cfg_bus.valid || cfg_bus.ready) begin
        if (pending_tolerances.size() != 0) begin
          cfg_bus.valid <= 1'b1;
          cfg_bus.data  <= pending_tolerances.pop_front();
        end else begin
          cfg_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on each accepted point, check each accepted result.
  always @(posedge clk_i) begin : verdict_monitor
    verdict_t want;
    verdict_t got;
    point_t   p;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        p.x      = in_bus.point_x;
        p.y      = in_bus.point_y;
        p.number = in_bus.point_number;
        classify_point(p, want);
        expected_verdicts = {expected_verdicts, want};
        points_accepted++;
      end
      if (out_bus.valid && out_bus.ready) begin
        got.number  = out_bus.echo_number;
        got.id      = out_bus.assigned_id;
        got.outcome = outcome_e'(out_bus.outcome);
        if (expected_verdicts.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: number %0d id %0d outcome %0d",
                     got.number, got.id, got.outcome);
          mismatch_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (got.number !== want.number || got.id !== want.id ||
              got.outcome !== want.outcome) begin
            if (mismatch_count < 10)
              $display("mismatch: expected number %0d id %0d outcome %0d, got %0d %0d %0d",
                       want.number, want.id, want.outcome,
                       got.number, got.id, got.outcome);
            mismatch_count++;
          end
        end
        results_seen++;
      end
    end
  end

  task automatic queue_point(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic [15:0] number);
    point_t p;
    p.x      = x;
    p.y      = y;
    p.number = number;
    sent_x = {sent_x, x};
    sent_y = {sent_y, y};
    points_queued++;
    pending_points = {pending_points, p};
  endtask

  // Write the tolerance only once every queued point has been answered.
  task automatic set_tolerance(input logic [TOL_W-1:0] value);
    int target;
    wait (results_seen == points_queued);
    repeat (8) @(posedge clk_i);
    target = tolerance_writes + 1;
    pending_tolerances = {pending_tolerances, value};
    wait (tolerance_writes == target);
    stim_tolerance = value;
  endtask

  // Offset that lands on, just inside, or anywhere around the tolerance boundary.
  function automatic longint near_offset(input logic [TOL_W-1:0] tol);
    longint lim;
    longint off;
    lim = longint'(tol) + 1;
    if (lim > 64'h3FFF_FFFF) lim = 64'h3FFF_FFFF;
    case ($urandom_range(3))
      0:       off = longint'(tol);
      1:       off = longint'(tol) - 1;
      default: off = longint'($urandom_range(32'(2 * lim))) - lim;
    endcase
    if ($urandom_range(1) == 1) off = -off;
    return off;
  endfunction

  function automatic logic signed [COORD_W-1:0] extreme_coord();
    case ($urandom_range(5))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      3:       return '1;
      4:       return COORD_MIN + 1;
      default: return COORD_MAX - 1;
    endcase
  endfunction

  // Mostly points aimed near earlier ones, with full-range noise, extremes
  // and a tight cluster around the origin.
  task automatic random_points(input int count);
    int                        i;
    int                        pick;
    int unsigned               roll;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    for (i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        pick = $urandom_range(sent_x.size() - 1);
        x = COORD_W'(longint'(sent_x[pick]) + near_offset(stim_tolerance));
        y = COORD_W'(longint'(sent_y[pick]) + near_offset(stim_tolerance));
      end else if (roll < 75) begin
        x = $urandom;
        y = $urandom;
      end else if (roll < 88) begin
        x = extreme_coord();
        y = ($urandom_range(1) == 1) ? extreme_coord() : COORD_W'($urandom);
      end else begin
        x = COORD_W'(int'($urandom_range(16)) - 8);
        y = COORD_W'(int'($urandom_range(16)) - 8);
      end
      queue_point(x, y, 16'($urandom_range(16'hFFFF)));
    end
  endtask

  // Stimulus: directed points first, then random phases under several tolerances.
  initial begin : stimulus
    stim_tolerance = TOL_RESET;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Reset tolerance: near hits, the strict boundary, and extreme corners.
    queue_point('0, '0, 16'd0);
    queue_point('0, 1, 16'd1);
    queue_point(2, -2, 16'd2);
    queue_point(3, '0, 16'd3);
    queue_point(COORD_MIN, COORD_MIN, 16'hFFFF);
    queue_point(COORD_MAX, COORD_MAX, 16'd5);
    queue_point(COORD_MIN + 2, COORD_MIN, 16'd6);
    queue_point(COORD_MAX, COORD_MIN, 16'd7);
    queue_point(COORD_MIN, COORD_MAX, 16'd8);
    queue_point('1, '1, 16'd9);
    queue_point(COORD_MAX - 2, COORD_MAX - 1, 16'd10);

    // Zero tolerance: even an exact repeat is a new point.
    set_tolerance('0);
    queue_point('0, '0, 16'd11);
    queue_point(COORD_MIN, COORD_MIN, 16'd12);

    // Widest tolerance: far points match, corners only just fail.
    set_tolerance(TOL_MAX);
    queue_point(1000, -1000, 16'd13);
    queue_point(COORD_MAX, COORD_MAX, 16'd14);
    queue_point(COORD_MIN, '0, 16'd15);
    queue_point(32'sh4000_0000, -32'sh4000_0000, 16'd16);

    set_tolerance(TOL_RESET);
    random_points(180);
    // Zero tolerance fills the store, so later phases run against a full one.
    set_tolerance('0);
    random_points(180);
    set_tolerance(TOL_W'($urandom_range(1000, 1)));
    random_points(180);
    set_tolerance(TOL_W'($urandom_range(32'h7FFF_FFFF, 32'h0010_0000)));
    random_points(180);
    set_tolerance(TOL_MAX);
    random_points(180);
    set_tolerance(TOL_W'(1));
    random_points(180);

    // Drain, then allow one more scan for any stray result.
    wait (results_seen == points_queued);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_verdicts.size() != 0) begin
      $display("%0d expected results never arrived", expected_verdicts.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tolerant_point_dedup_renumber verification clean");
    end else begin
      $display("tolerant_point_dedup_renumber verification failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run with a full store.
  initial begin : watchdog
    #3_000_000;
    $display("tolerant_point_dedup_renumber verification failed");
    $finish;
  end

endmodule

`default_nettype wire
